// ----- design/qph_pkg.sv -----
`timescale 1ns / 1ps

package qph_pkg;

   localparam int SLOT_COUNT_DEFAULT = 7;

   localparam int KEY_W       = 31;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 3;
   localparam int PROBE_OUT_W = 3;

   // home slot reduction: key bits consumed per step and steps per key
   localparam int HOME_BITS_PER_STEP = 8;
   localparam int HOME_STEPS         = (KEY_W + HOME_BITS_PER_STEP - 1) / HOME_BITS_PER_STEP;
   localparam int HOME_BITS          = HOME_STEPS * HOME_BITS_PER_STEP;
   localparam int HOME_STEP_W        = (HOME_STEPS > 1) ? $clog2(HOME_STEPS) : 1;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_FIND   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

   typedef struct packed {
      logic                      cmd;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [SLOT_OUT_W-1:0]     slot_index;
      logic [PROBE_OUT_W-1:0]    probe_count;
      logic signed [VALUE_W-1:0] found_value;
   } rsp_type;

   typedef struct packed {
      logic                      occupied;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } slot_type;

endpackage

// ----- design/qph_home_unit.sv -----
`timescale 1ns / 1ps

module qph_home_unit #(
   parameter int SLOT_COUNT = qph_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [qph_pkg::KEY_W-1:0]     key,
   output logic                          done,
   output logic [$clog2(SLOT_COUNT)-1:0] home
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(SLOT_COUNT);

   logic [qph_pkg::HOME_BITS-1:0]   sh_ff, sh_in;
   logic [IDX_W-1:0]                r_ff, r_in;
   logic [qph_pkg::HOME_STEP_W-1:0] step_ff, step_in;
   logic                            active_ff, active_in;
   logic                            done_ff, done_in;

   // remainder so far, shifted left one key bit at a time, reduced by one subtract
   always_comb begin
      logic [IDX_W:0]   t;
      logic [IDX_W-1:0] r;
      r = r_ff;
      for (int j = 0; j < qph_pkg::HOME_BITS_PER_STEP; j++) begin
         t = {r, sh_ff[qph_pkg::HOME_BITS-1-j]};
         if (t >= N_EXT) begin
            t = t - N_EXT;
         end
         r = t[IDX_W-1:0];
      end

      sh_in     = sh_ff;
      r_in      = r_ff;
      step_in   = step_ff;
      active_in = active_ff;
      done_in   = done_ff;
      if (start) begin
         sh_in     = qph_pkg::HOME_BITS'(key);
         r_in      = '0;
         step_in   = '0;
         active_in = 1'b1;
         done_in   = 1'b0;
      end else if (active_ff) begin
         sh_in   = sh_ff << qph_pkg::HOME_BITS_PER_STEP;
         r_in    = r;
         step_in = step_ff + 1'b1;
         if (step_ff == qph_pkg::HOME_STEP_W'(qph_pkg::HOME_STEPS-1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      r_ff    <= r_in;
      step_ff <= step_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done = done_ff;
   assign home = r_ff;

endmodule

// ----- design/qph_slot_ram.sv -----
`timescale 1ns / 1ps

module qph_slot_ram #(
   parameter int SLOT_COUNT = qph_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
   input  qph_pkg::slot_type             wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
   output qph_pkg::slot_type             rd_data
);

   qph_pkg::slot_type mem [SLOT_COUNT];
   qph_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/quadratic_probe_hash_table_top.sv -----
`timescale 1ns / 1ps
// An accepted start runs home slot reduction and one slot read, then one probe per cycle until
// the rsp_valid strobe; slots probed per request range over 1..SLOT_COUNT.
// A new request is accepted only while idle; busy stays high until the result strobe.
// Reset: synchronous, active high; a clearing pass then empties every slot, with busy high
// throughout. The receiver cannot stall, so results never wait.
module quadratic_probe_hash_table_top #(
   parameter int SLOT_COUNT = qph_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qph_pkg::req_type req_data,
   output logic             rsp_valid,
   output qph_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(SLOT_COUNT);

   localparam int SLOT_OUT_PAD  = qph_pkg::SLOT_OUT_W;
   localparam int PROBE_OUT_PAD = qph_pkg::PROBE_OUT_W;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_HOME  = 2'd2;
   localparam logic [1:0] S_CHECK = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] inc_ff, inc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   qph_pkg::req_type req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   qph_pkg::rsp_type rsp_ff, rsp_in;

   logic              home_done;
   logic [IDX_W-1:0]  home;
   logic              accept;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   qph_pkg::slot_type wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   qph_pkg::slot_type rd_data;

   logic [IDX_W:0]         next_slot_sum;
   logic [IDX_W:0]         next_inc_sum;
   logic [IDX_W-1:0]       next_slot;
   logic [IDX_W-1:0]       next_inc;
   logic [IDX_W+SLOT_OUT_PAD-1:0] slot_ext;
   logic [CNT_W+PROBE_OUT_PAD-1:0] cnt_ext;
   logic                   last_probe;

   assign accept = start && !busy;

   qph_home_unit #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_home (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .key  (req_data.key),
      .done (home_done),
      .home (home)
   );

   qph_slot_ram #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // step the probe incrementally: offset p*p grows by 2p+1, all kept mod SLOT_COUNT
   always_comb begin
      next_slot_sum = {1'b0, slot_ff} + {1'b0, inc_ff};
      if (next_slot_sum >= N_EXT) begin
         next_slot_sum = next_slot_sum - N_EXT;
      end
      next_inc_sum = {1'b0, inc_ff} + (IDX_W+1)'(2);
      if (next_inc_sum >= N_EXT) begin
         next_inc_sum = next_inc_sum - N_EXT;
      end
   end

   assign next_slot  = next_slot_sum[IDX_W-1:0];
   assign next_inc   = next_inc_sum[IDX_W-1:0];
   assign slot_ext   = {{SLOT_OUT_PAD{1'b0}}, slot_ff};
   assign cnt_ext    = {{PROBE_OUT_PAD{1'b0}}, cnt_ff};
   assign last_probe = (cnt_ff == CNT_W'(SLOT_COUNT));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      inc_in       = inc_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = '{occupied: 1'b1, key: req_ff.key, value: req_ff.value};
      rd_en        = 1'b0;
      rd_addr      = next_slot;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en            = 1'b1;
            wr_addr          = clr_ff;
            wr_data.occupied = 1'b0;
            clr_in           = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(SLOT_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = S_HOME;
            end
         end
         S_HOME: begin
            if (home_done) begin
               rd_en    = 1'b1;
               rd_addr  = home;
               slot_in  = home;
               inc_in   = IDX_W'(1);
               cnt_in   = CNT_W'(1);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            rsp_in.slot_index  = '0;
            rsp_in.probe_count = cnt_ext[qph_pkg::PROBE_OUT_W-1:0];
            rsp_in.found_value = '0;
            rsp_in.status      = qph_pkg::ST_MISSING;
            priority if (!rd_data.occupied) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (req_ff.cmd == qph_pkg::CMD_INSERT) begin
                  wr_en             = 1'b1;
                  rsp_in.status     = qph_pkg::ST_INSERTED;
                  rsp_in.slot_index = slot_ext[qph_pkg::SLOT_OUT_W-1:0];
               end
            end else if (req_ff.cmd == qph_pkg::CMD_FIND && rd_data.key == req_ff.key) begin
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
               rsp_in.status      = qph_pkg::ST_FOUND;
               rsp_in.slot_index  = slot_ext[qph_pkg::SLOT_OUT_W-1:0];
               rsp_in.found_value = rd_data.value;
            end else if (last_probe) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (req_ff.cmd == qph_pkg::CMD_INSERT) begin
                  rsp_in.status = qph_pkg::ST_FULL;
               end
            end else begin
               // advance: fetch the next slot while this one is being checked
               rd_en   = 1'b1;
               rd_addr = next_slot;
               slot_in = next_slot;
               inc_in  = next_inc;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      inc_ff  <= inc_in;
      cnt_ff  <= cnt_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("result strobe outside idle");

   a_accept_home: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_HOME && !home_done)
      else $error("accepted beat did not start home reduction");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> cnt_ff != '0 && cnt_ff <= CNT_W'(SLOT_COUNT))
      else $error("probe count out of range");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> {1'b0, slot_ff} < N_EXT && {1'b0, inc_ff} < N_EXT)
      else $error("probe slot or step out of range");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != qph_pkg::ST_FOUND |-> rsp_ff.found_value == '0)
      else $error("value reported without a hit");

endmodule
